[hw/rtl/spq_pkg.sv]
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } opcode_t;

  typedef struct packed {
    logic    exec;
    opcode_t op;
    logic    dump_sel;
    logic    rd_step;
  } spq_cmd_t;

  typedef struct packed {
    logic rd_last;
  } spq_sts_t;

endpackage

[hw/rtl/spq_if.sv]
interface spq_in_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [KEY_W-1:0]    new_key;
  logic [TAG_W-1:0]    new_tag;

  modport source (output valid, output opcode, output new_key, output new_tag, input ready);
  modport sink   (input valid, input opcode, input new_key, input new_tag, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    out_key;
  logic [TAG_W-1:0]    out_tag;
  logic                is_empty;
  logic                overflow;
  logic                last_item;

  modport source (output valid, output out_key, output out_tag, output is_empty,
                  output overflow, output last_item, input ready);
  modport sink   (input valid, input out_key, input out_tag, input is_empty,
                  input overflow, input last_item, output ready);
endinterface

[hw/rtl/spq_ctrl.sv]
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  input  logic       out_ready,
  input  spq_sts_t   sts,
  output logic       in_ready,
  output logic       out_valid,
  output logic       out_last,
  output spq_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_DUMP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r;
  logic   out_vld_r;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid && in_rdy_r;
  assign out_acc = out_vld_r && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (opcode_t'(in_opcode) == OP_DUMP) ? S_DUMP : S_RESP;
        end
      end
      S_RESP: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_acc && sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_rdy_r  <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_rdy_r  <= (state_nxt == S_IDLE);
      out_vld_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_ready     = in_rdy_r;
  assign out_valid    = out_vld_r;
  assign out_last     = (state_r == S_DUMP) ? sts.rd_last : 1'b1;
  assign cmd.exec     = in_acc;
  assign cmd.op       = opcode_t'(in_opcode);
  assign cmd.dump_sel = (state_r == S_DUMP);
  assign cmd.rd_step  = out_acc && (state_r == S_DUMP);

endmodule

[hw/rtl/spq_dpath.sv]
module spq_dpath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_cmd_t         cmd,
  input  logic [KEY_W-1:0] new_key,
  input  logic [TAG_W-1:0] new_tag,
  output spq_sts_t         sts,
  output logic [KEY_W-1:0] out_key,
  output logic [TAG_W-1:0] out_tag,
  output logic             is_empty,
  output logic             overflow
);

  localparam int SK = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [SK-1:0]    key_r [CAPACITY];
  logic [TAG_W-1:0] tag_r [CAPACITY];
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    rd_idx_r;
  logic             ovf_r;
  logic [SK-1:0]    key_in;
  logic [CAPACITY-1:0] ble;
  logic [CAPACITY-1:0] ahead;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;
  logic [IW-1:0]    sel_idx;

  assign key_in  = new_key[SK-1:0];
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign do_push = cmd.exec && (cmd.op == OP_PUSH) && !full;
  assign do_pop  = cmd.exec && (cmd.op == OP_POP) && !empty;

  // Each cell decides on its own whether it holds, takes the new entry or shifts.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [SK-1:0]    lo_key, hi_key, key_nxt;
    logic [TAG_W-1:0] lo_tag, hi_tag, tag_nxt;
    logic             prev_ahead;
    logic             valid;

    assign valid = (CW'(g) < count_r);

    if (g == 0) begin : g_head
      assign ble[g]     = valid && (key_in >= key_r[g]);
      assign lo_key     = key_in;
      assign lo_tag     = new_tag;
      assign prev_ahead = 1'b1;
    end else begin : g_body
      assign ble[g]     = valid && (key_r[g] < key_in);
      assign lo_key     = key_r[g-1];
      assign lo_tag     = tag_r[g-1];
      assign prev_ahead = ahead[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign hi_key = key_r[g];
      assign hi_tag = tag_r[g];
    end else begin : g_mid
      assign hi_key = key_r[g+1];
      assign hi_tag = tag_r[g+1];
    end

    assign ahead[g] = ble[g] && ble[0];

    always_comb begin
      key_nxt = key_r[g];
      tag_nxt = tag_r[g];
      if (do_push && !ahead[g]) begin
        if (prev_ahead) begin
          key_nxt = key_in;
          tag_nxt = new_tag;
        end else begin
          key_nxt = lo_key;
          tag_nxt = lo_tag;
        end
      end else if (do_pop) begin
        key_nxt = hi_key;
        tag_nxt = hi_tag;
      end
    end

    always_ff @(posedge clk) begin
      key_r[g] <= key_nxt;
      tag_r[g] <= tag_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_idx_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.exec) begin
        rd_idx_r <= '0;
        ovf_r    <= (cmd.op == OP_PUSH) && full;
      end else if (cmd.rd_step) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
    end
  end

  assign sel_idx     = cmd.dump_sel ? rd_idx_r : '0;
  assign sts.rd_last = empty || ((CW'(rd_idx_r) + CW'(1)) == count_r);
  assign out_key     = empty ? '0 : KEY_W'(key_r[sel_idx]);
  assign out_tag     = empty ? '0 : tag_r[sel_idx];
  assign is_empty    = empty;
  assign overflow    = ovf_r;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// The result of an item is valid in the cycle after the item is accepted.
// Push, pop and peek take a new item only once the last result is accepted; a read-out
// gives one entry per cycle while out_ready is high, from a registered index.
// Every insert or pop is done by a row of compare-and-shift cells.
// Reset clears the entry count, read index, overflow flag and handshake state, not the cells.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  spq_in_if.sink   in_ch,
  spq_out_if.source out_ch
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_last  (out_ch.last_item),
    .cmd       (cmd)
  );

  spq_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .new_key  (in_ch.new_key),
    .new_tag  (in_ch.new_tag),
    .sts      (sts),
    .out_key  (out_ch.out_key),
    .out_tag  (out_ch.out_tag),
    .is_empty (out_ch.is_empty),
    .overflow (out_ch.overflow)
  );

endmodule

[tb/spq_checker.sv]
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [KEY_W-1:0] in_key,
  input  logic [TAG_W-1:0] in_tag,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [KEY_W-1:0] out_key,
  input  logic [TAG_W-1:0] out_tag,
  input  logic             out_is_empty,
  input  logic             out_overflow,
  input  logic             out_last_item,
  output int               fail_count,
  output int               outstanding
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             empty;
    logic             ovf;
    logic             last;
  } result_t;

  result_t          expected_results[$];
  logic [KEY_W-1:0] queue_keys[CAPACITY];
  logic [TAG_W-1:0] queue_tags[CAPACITY];
  int               queue_len = 0;
  int               fails = 0;
  int               pending = 0;
  result_t          want;
  result_t          got;

  assign fail_count  = fails;
  assign outstanding = pending;

  task automatic post_head(logic ovf);
    result_t r;
    if (queue_len == 0) begin
      r = '{'0, '0, 1'b1, ovf, 1'b1};
    end else begin
      r = '{queue_keys[0], queue_tags[0], 1'b0, ovf, 1'b1};
    end
    expected_results.push_back(r);
  endtask

  task automatic apply_op(opcode_t op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    int      pos;
    int      i;
    result_t r;
    case (op)
      OP_PUSH: begin
        if (queue_len >= CAPACITY) begin
          post_head(1'b1);
        end else begin
          // An equal key at the head sends the new entry right behind the head.
          if (queue_len == 0 || key < queue_keys[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < queue_len && queue_keys[pos] < key) pos++;
          end
          for (i = queue_len; i > pos; i--) begin
            queue_keys[i] = queue_keys[i-1];
            queue_tags[i] = queue_tags[i-1];
          end
          queue_keys[pos] = key;
          queue_tags[pos] = tag;
          queue_len++;
          post_head(1'b0);
        end
      end
      OP_POP: begin
        if (queue_len > 0) begin
          for (i = 1; i < queue_len; i++) begin
            queue_keys[i-1] = queue_keys[i];
            queue_tags[i-1] = queue_tags[i];
          end
          queue_len--;
        end
        post_head(1'b0);
      end
      OP_PEEK: begin
        post_head(1'b0);
      end
      default: begin
        if (queue_len == 0) begin
          post_head(1'b0);
        end else begin
          for (i = 0; i < queue_len; i++) begin
            r = '{queue_keys[i], queue_tags[i], 1'b0, 1'b0, (i + 1 == queue_len)};
            expected_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      queue_len = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_key, out_tag, out_is_empty, out_overflow, out_last_item};
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: key %h tag %h empty %b overflow %b last %b",
                   $time, got.key, got.tag, got.empty, got.ovf, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch: expected key %h tag %h empty %b overflow %b last %b",
                     $time, want.key, want.tag, want.empty, want.ovf, want.last);
            $display("%0t:           actual key %h tag %h empty %b overflow %b last %b",
                     $time, got.key, got.tag, got.empty, got.ovf, got.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_op(opcode_t'(in_opcode), in_key, in_tag);
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb.sv]
module tb;
  import spq_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic no_idle;
  logic hold_req;
  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  sorted_priority_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_opcode     (in_ch.opcode),
    .in_key        (in_ch.new_key),
    .in_tag        (in_ch.new_tag),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_key       (out_ch.out_key),
    .out_tag       (out_ch.out_tag),
    .out_is_empty  (out_ch.is_empty),
    .out_overflow  (out_ch.overflow),
    .out_last_item (out_ch.last_item),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic opcode_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_PUSH;
    if (r < 75) return OP_POP;
    if (r < 87) return OP_PEEK;
    return OP_DUMP;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic send_item(opcode_t op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.new_key <= key;
    in_ch.new_tag <= tag;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_item(pick_op(), pick_key(), $urandom);
    end
  endtask

  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (hold_req && !held) begin
        stall = stall + HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int n;
    rst_n         = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_PUSH;
    in_ch.new_key = '0;
    in_ch.new_tag = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_POP,  '0, '0);
    send_item(OP_PEEK, '0, '0);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_PUSH, 16'h8000, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 16'h8000, 32'h0000_0001);
    send_item(OP_PUSH, 16'h8000, 32'h0000_0002);
    send_item(OP_PUSH, 16'h9000, 32'h1234_5678);
    send_item(OP_PUSH, 16'h9000, 32'h8765_4321);
    send_item(OP_PUSH, 16'hFFFF, 32'hAAAA_5555);
    send_item(OP_PUSH, 16'h0000, 32'h0000_0000);
    send_item(OP_PUSH, 16'h0000, 32'h5555_AAAA);
    send_item(OP_PEEK, '1, '1);
    send_item(OP_DUMP, '1, '1);
    send_item(OP_POP,  '0, '0);
    send_item(OP_POP,  '0, '0);
    send_item(OP_DUMP, '0, '0);

    // The sink stops for a long stretch while the source keeps offering items.
    hold_req = 1'b1;
    for (n = 0; n < 20; n++) begin
      send_item((n == 8) ? OP_DUMP : OP_PUSH, pick_key(), $urandom);
    end
    wait (outstanding == 0);
    @(negedge clk);

    no_idle = 1'b1;
    for (n = 0; n < CAPACITY + 2; n++) begin
      send_item(OP_PUSH, pick_key(), $urandom);
    end
    no_idle = 1'b0;
    send_item(OP_DUMP, '0, '0);
    send_item(OP_PEEK, '0, '0);
    send_item(OP_PUSH, '0, '1);

    send_random(40);
    in_ch.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sorted_priority_queue.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dpath.sv
hw/rtl/sorted_priority_queue.sv
tb/spq_checker.sv
tb/tb.sv
